/* rtl/sle_pkg.sv */
// sle_pkg: shared constants of the serial line editor
// character codes, register reset value and default store depth
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sle_pkg;

	localparam int LINE_DEPTH_DEF = 32;

	localparam int MAXLEN_W = 6;
	localparam int BYTE_W   = 8;

	localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RST = 6'd32;

	localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_BS = 8'h08;
	localparam logic [BYTE_W-1:0] CH_SP = 8'h20;
	localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_LINE = 1'b1;

endpackage
`default_nettype wire

/* rtl/sle_ram.sv */
// sle_ram: generic single write, single read port memory with registered read
// read data holds while no read is issued
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module sle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/serial_line_editor_with_echo_top.sv */
// serial_line_editor_with_echo_top: line editor with echo over a line store memory
// depends on sle_pkg and sle_ram
//
//   channel  direction  handshake              payload
//   rx       in         rx_valid / rx_ready    rx_byte
//   out      out        out_valid / out_ready  out_kind, out_byte, last
//   cfg      in         cfg_we                 cfg_wdata (max_length)
//
// one item at a time; a carriage return reads the line from the store memory (one
// read port, registered read), one line byte per cycle while the output is not
// stalled; the output register takes the next result in the cycle of its transfer;
// a stalled output holds the sequencer. reset clears fill count and sequencer, not
// the store
`timescale 1ns / 1ps
`default_nettype none
module serial_line_editor_with_echo_top #(
	parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           rx_valid,
	output logic                                rx_ready,
	input  wire logic [sle_pkg::BYTE_W-1:0]     rx_byte,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                out_kind,
	output logic      [sle_pkg::BYTE_W-1:0]     out_byte,
	output logic                                last,
	input  wire logic                           cfg_we,
	input  wire logic [sle_pkg::MAXLEN_W-1:0]   cfg_wdata
);
	import sle_pkg::*;

	localparam int CW = $clog2(LINE_DEPTH);
	localparam logic [MAXLEN_W:0] DEPTH_C = (MAXLEN_W+1)'(LINE_DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_LF   = 3'd2;
	localparam logic [2:0] ST_LINE = 3'd3;
	localparam logic [2:0] ST_SP   = 3'd4;
	localparam logic [2:0] ST_BS2  = 3'd5;

	logic [2:0]          state_q, state_d;
	logic [BYTE_W-1:0]   byte_q;
	logic [MAXLEN_W-1:0] max_length_q;
	logic [CW-1:0]       fill_q, fill_d;
	logic [CW-1:0]       idx_q, idx_d;

	logic                out_valid_q, out_kind_q, last_q;
	logic [BYTE_W-1:0]   out_byte_q;

	logic                emit;
	logic                emit_kind, emit_last;
	logic [BYTE_W-1:0]   emit_byte;
	logic                slot_free;
	logic [MAXLEN_W:0]   cap;
	logic                store_ok;

	logic                ram_we, ram_re;
	logic [CW-1:0]       ram_raddr;
	logic [BYTE_W-1:0]   ram_rdata;

	assign slot_free = !out_valid_q || out_ready;
	assign cap       = ({1'b0, max_length_q} > DEPTH_C) ? DEPTH_C : {1'b0, max_length_q};
	assign store_ok  = ((MAXLEN_W+1)'(fill_q) + (MAXLEN_W+1)'(1)) < cap;
	assign rx_ready  = (state_q == ST_IDLE);

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		idx_d     = idx_q;
		emit      = 1'b0;
		emit_kind = KIND_ECHO;
		emit_byte = byte_q;
		emit_last = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (rx_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (byte_q)
					CH_CR: begin
						if (slot_free) begin
							emit      = 1'b1;
							emit_byte = CH_CR;
							state_d   = ST_LF;
						end
					end
					CH_BS: begin
						if (fill_q == '0) begin
							state_d = ST_IDLE;
						end else if (slot_free) begin
							emit      = 1'b1;
							emit_byte = CH_BS;
							fill_d    = fill_q - CW'(1);
							state_d   = ST_SP;
						end
					end
					default: begin
						if (!store_ok) begin
							state_d = ST_IDLE;
						end else if (slot_free) begin
							emit      = 1'b1;
							emit_last = 1'b1;
							ram_we    = 1'b1;
							fill_d    = fill_q + CW'(1);
							state_d   = ST_IDLE;
						end
					end
				endcase
			end
			ST_LF: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_byte = CH_LF;
					ram_re    = 1'b1;
					idx_d     = '0;
					state_d   = ST_LINE;
				end
			end
			ST_LINE: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_kind = KIND_LINE;
					if (idx_q == fill_q) begin
						emit_byte = CH_NUL;
						emit_last = 1'b1;
						fill_d    = '0;
						state_d   = ST_IDLE;
					end else begin
						emit_byte = ram_rdata;
						idx_d     = idx_q + CW'(1);
						ram_re    = 1'b1;
						ram_raddr = idx_q + CW'(1);
					end
				end
			end
			ST_SP: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_byte = CH_SP;
					state_d   = ST_BS2;
				end
			end
			ST_BS2: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_byte = CH_BS;
					emit_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			idx_q        <= '0;
			max_length_q <= MAX_LENGTH_RST;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			idx_q   <= idx_d;
			if (cfg_we) begin
				max_length_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_q <= rx_byte;
		end
		if (emit) begin
			out_kind_q <= emit_kind;
			out_byte_q <= emit_byte;
			last_q     <= emit_last;
		end
	end

	sle_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(LINE_DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q),
		.wdata(byte_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule
`default_nettype wire

/* rtl/sle_checker.sv */
// sle_checker: port level checks of the serial line editor
// depends on sle_pkg; bound to serial_line_editor_with_echo_top
`timescale 1ns / 1ps
`default_nettype none
module sle_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic                       out_kind,
	input wire logic [sle_pkg::BYTE_W-1:0] out_byte,
	input wire logic                       last
);
	import sle_pkg::*;

	// a stalled output transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
	else $error("output changed while stalled");

	// a line always ends with a zero terminator
	a_line_term: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_LINE && last |-> out_byte == CH_NUL)
	else $error("line end without terminator");

	// echo bytes that do not end an item are control sequences only
	a_echo_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_ECHO && !last |->
			out_byte == CH_CR || out_byte == CH_LF || out_byte == CH_BS || out_byte == CH_SP)
	else $error("unexpected echo byte inside a sequence");

	// a carriage return echo is never the final result of an item
	a_cr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_ECHO && out_byte == CH_CR |-> !last)
	else $error("carriage return echo marked last");

endmodule

bind serial_line_editor_with_echo_top sle_checker u_sle_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_kind (out_kind),
	.out_byte (out_byte),
	.last     (last)
);
`default_nettype wire

/* tb/sv/serial_line_editor_with_echo_top_test.sv */
// self-checking testbench for serial_line_editor_with_echo_top: directed and random typing
// with echo/line readout predicted in the bench, random stalls on both channels
// depends on sle_pkg and the serial_line_editor_with_echo_top rtl
`timescale 1ns / 1ps
module serial_line_editor_with_echo_top_test;
	import sle_pkg::*;

	localparam int STORE_DEPTH   = 32;
	localparam int SETTLE_CYCLES = 12;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 190;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] data;
		logic              last;
	} editor_out_t;

	logic                clk;
	logic                arst_n;
	logic                rx_valid;
	logic                rx_ready;
	logic [BYTE_W-1:0]   rx_byte;
	logic                out_valid;
	logic                out_ready;
	logic                out_kind;
	logic [BYTE_W-1:0]   out_byte;
	logic                last;
	logic                cfg_we;
	logic [MAXLEN_W-1:0] cfg_wdata;

	// bench copy of the editor state
	logic [MAXLEN_W-1:0] max_len_reg;
	int                  line_len;
	logic [BYTE_W-1:0]   line_chars [STORE_DEPTH];

	editor_out_t echo_line_q [$];
	int          rx_count;
	int          error_count;
	int          idle_cycles;
	int          out_hold_cycles;
	bit          no_idle;

	serial_line_editor_with_echo_top #(
		.LINE_DEPTH(STORE_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_kind (out_kind),
		.out_byte (out_byte),
		.last     (last),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function void push_echo_line(input logic kind, input logic [BYTE_W-1:0] data,
			input logic fin);
		editor_out_t item;
		item.kind = kind;
		item.data = data;
		item.last = fin;
		echo_line_q.push_back(item);
	endfunction

	function void predict_line_edit(input logic [BYTE_W-1:0] b);
		int cap;
		int n;
		cap = (int'(max_len_reg) > STORE_DEPTH) ? STORE_DEPTH : int'(max_len_reg);
		if (b == CH_CR) begin
			n = (line_len > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : line_len;
			push_echo_line(KIND_ECHO, CH_CR, 1'b0);
			push_echo_line(KIND_ECHO, CH_LF, 1'b0);
			for (int i = 0; i < n; i++)
				push_echo_line(KIND_LINE, line_chars[i], 1'b0);
			push_echo_line(KIND_LINE, CH_NUL, 1'b1);
			line_len = 0;
		end else if (b == CH_BS) begin
			if (line_len > 0) begin
				line_len--;
				push_echo_line(KIND_ECHO, CH_BS, 1'b0);
				push_echo_line(KIND_ECHO, CH_SP, 1'b0);
				push_echo_line(KIND_ECHO, CH_BS, 1'b1);
			end
		end else if (cap >= 1 && line_len < cap - 1) begin
			line_chars[line_len] = b;
			line_len++;
			push_echo_line(KIND_ECHO, b, 1'b1);
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		editor_out_t exp_item;
		if (arst_n && out_valid && out_ready) begin
			if (echo_line_q.size() == 0) begin
				$error("unexpected result kind %0d byte %02h last %0d",
					out_kind, out_byte, last);
				error_count++;
			end else begin
				exp_item = echo_line_q.pop_front();
				if (out_kind !== exp_item.kind) begin
					$error("out_kind expected %0d actual %0d", exp_item.kind, out_kind);
					error_count++;
				end
				if (out_byte !== exp_item.data) begin
					$error("out_byte expected %02h actual %02h", exp_item.data, out_byte);
					error_count++;
				end
				if (last !== exp_item.last) begin
					$error("last expected %0d actual %0d", exp_item.last, last);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_valid && rx_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// result receiver with random and long stalls
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (out_hold_cycles > 0) begin
				gap = out_hold_cycles;
				out_hold_cycles = 0;
			end else begin
				gap = no_idle ? 0 : $urandom_range(0, 10);
			end
			@(negedge clk);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	task automatic send_rx_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!(rx_valid && rx_ready));
		predict_line_edit(b);
		rx_count++;
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		rx_valid <= 1'b0;
		while (echo_line_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_max_length(input logic [MAXLEN_W-1:0] v);
		wait_all_results();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		max_len_reg = v;
	endtask

	function automatic logic [BYTE_W-1:0] plain_char();
		logic [BYTE_W-1:0] b;
		do b = BYTE_W'($urandom_range(0, 255)); while (b == CH_CR || b == CH_BS);
		return b;
	endfunction

	task automatic type_line(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				send_rx_byte(CH_BS);
			else if (r < 11)
				send_rx_byte(BYTE_W'($urandom_range(0, 255)));
			else
				send_rx_byte(plain_char());
			if ($urandom_range(0, 49) == 0)
				wait_all_results();
		end
		send_rx_byte(CH_CR);
	endtask

	task automatic test_basic_editing();
		set_max_length(MAX_LENGTH_RST);
		send_rx_byte(CH_BS);
		send_rx_byte(CH_CR);
		send_rx_byte(8'h41);
		send_rx_byte(CH_NUL);
		send_rx_byte(8'hFF);
		send_rx_byte(8'h7F);
		send_rx_byte(CH_BS);
		send_rx_byte(CH_CR);
	endtask

	task automatic test_line_full();
		set_max_length(6'd3);
		for (int i = 0; i < 4; i++)
			send_rx_byte(BYTE_W'(8'h30 + i));
		send_rx_byte(CH_CR);
	endtask

	task automatic test_tiny_capacity();
		set_max_length(6'd0);
		send_rx_byte(8'h55);
		send_rx_byte(CH_CR);
		set_max_length(6'd1);
		send_rx_byte(8'hAA);
		send_rx_byte(CH_CR);
	endtask

	task automatic test_lowered_mid_line();
		set_max_length(6'd32);
		for (int i = 0; i < 5; i++)
			send_rx_byte(BYTE_W'(8'h61 + i));
		set_max_length(6'd2);
		send_rx_byte(8'h7A);
		send_rx_byte(CH_BS);
		send_rx_byte(8'h79);
		send_rx_byte(CH_CR);
	endtask

	task automatic test_saturated_capacity();
		set_max_length(6'd63);
		for (int i = 0; i < 34; i++)
			send_rx_byte(plain_char());
		send_rx_byte(CH_CR);
		set_max_length(6'd40);
		type_line(36);
	endtask

	task automatic test_output_backpressure();
		set_max_length(MAX_LENGTH_RST);
		out_hold_cycles = 300;
		for (int i = 0; i < 12; i++)
			send_rx_byte(plain_char());
		send_rx_byte(CH_CR);
		send_rx_byte(plain_char());
		send_rx_byte(CH_BS);
		send_rx_byte(CH_CR);
	endtask

	task automatic test_sender_pause();
		send_rx_byte(8'h48);
		send_rx_byte(8'h49);
		wait_all_results();
		send_rx_byte(CH_BS);
		wait_all_results();
		send_rx_byte(CH_CR);
	endtask

	task automatic test_random_typing();
		int stop_at;
		int r;
		int lines;
		logic [MAXLEN_W-1:0] extremes [7];
		extremes = '{6'd0, 6'd1, 6'd2, 6'd31, 6'd32, 6'd33, 6'd63};
		stop_at = rx_count + RANDOM_ITEMS;
		while (rx_count < stop_at) begin
			r = $urandom_range(0, 9);
			if (r < 2)
				set_max_length(extremes[$urandom_range(0, 6)]);
			else
				set_max_length(MAXLEN_W'($urandom_range(1, 32)));
			no_idle = ($urandom_range(0, 3) == 0);
			lines = $urandom_range(2, 6);
			for (int i = 0; i < lines; i++) begin
				if ($urandom_range(0, 7) == 0)
					type_line($urandom_range(25, 40));
				else
					type_line($urandom_range(0, 6));
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n          = 1'b0;
		rx_valid        = 1'b0;
		rx_byte         = '0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		max_len_reg     = MAX_LENGTH_RST;
		line_len        = 0;
		rx_count        = 0;
		error_count     = 0;
		idle_cycles     = 0;
		out_hold_cycles = 0;
		no_idle         = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_basic_editing();
		test_line_full();
		test_tiny_capacity();
		test_lowered_mid_line();
		test_output_backpressure();
		test_sender_pause();
		test_saturated_capacity();
		test_random_typing();

		wait_all_results();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
